[hdl/hofc_pkg.sv]
package hofc_pkg;

    // Default map sizes
    localparam int unsigned MAX_CELLS_DEF = 4096;
    localparam int unsigned MAX_CALOS_DEF = 1024;

    // Port widths
    localparam int unsigned ID_W       = 16;
    localparam int unsigned OVERLAP_W  = 16;
    localparam int unsigned FREE_W     = 13;
    localparam int unsigned CELLS_W    = 13;
    localparam int unsigned CALOS_W    = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    // Id/count compare width: holds any id and a map size up to 65536
    localparam int unsigned CNT_W = 17;

    localparam logic [OVERLAP_W-1:0] REPEAT_MAX = '1;
    localparam logic [FREE_W-1:0]    COUNT_MAX  = '1;

    localparam logic [CELLS_W-1:0] CELLS_RST = CELLS_W'(4096);
    localparam logic [CALOS_W-1:0] CALOS_RST = CALOS_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS = 1'b0,
        CFG_CALOS = 1'b1
    } cfg_idx_t;

    // Request codes; REQ_NONE is also used internally for dropped hits
    typedef enum logic [1:0] {
        REQ_CELL = 2'd0,
        REQ_CALO = 2'd1,
        REQ_END  = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

endpackage

[hdl/hofc_seen_map.sv]
module hofc_seen_map
    import hofc_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_CELLS_DEF,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data
);

    // one seen bit per id; read returns old data on a same-cycle write
    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/hit_overlap_and_free_counter.sv]
// Channel   | Direction | Signals                                | Handshake
// ----------+-----------+----------------------------------------+---------------------
// request   | in        | req_type[1:0], hit_id[15:0]            | start & !busy
// result    | out       | overlap_count[15:0], free_count[12:0]  | done, one cycle
// config    | in        | cfg_index[0], cfg_data[12:0]           | cfg_valid & cfg_ready
//
// Hits go through a two-stage read-modify-write of the seen maps at one request
// per cycle while busy is low; a repeat hit on the previous request's id is forwarded.
// An end-of-scenario request passes the stage-1 op register and then the done register;
// busy stays high while it is in stage 1 and through the clearing sweep that follows.
// After reset the sweep alone runs first.
// cfg_ready is always high; results cannot be stalled.
module hit_overlap_and_free_counter
    import hofc_pkg::*;
#(
    parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
    parameter int unsigned MAX_CALOS = MAX_CALOS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [ID_W-1:0]       hit_id,
    // result
    output logic                  done,
    output logic [OVERLAP_W-1:0]  overlap_count,
    output logic [FREE_W-1:0]     free_count,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned CALO_AW   = (MAX_CALOS > 1) ? $clog2(MAX_CALOS) : 1;
    localparam int unsigned SWEEP_LEN = (MAX_CELLS > MAX_CALOS) ? MAX_CELLS : MAX_CALOS;
    localparam int unsigned SW_AW     = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
    localparam int unsigned TOT_W     = CNT_W + 1;

    localparam logic [CNT_W-1:0] MAX_CELLS_C = CNT_W'(MAX_CELLS);
    localparam logic [CNT_W-1:0] MAX_CALOS_C = CNT_W'(MAX_CALOS);
    localparam logic [SW_AW-1:0] SWEEP_LAST  = SW_AW'(SWEEP_LEN - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CELLS_W-1:0] cells_cfg_reg;
    logic [CALOS_W-1:0] calos_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_cfg_reg <= CELLS_RST;
            calos_cfg_reg <= CALOS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CELLS: cells_cfg_reg <= cfg_data[CELLS_W-1:0];
                CFG_CALOS: calos_cfg_reg <= cfg_data[CALOS_W-1:0];
                default:   ;
            endcase
        end
    end

    // effective sizes: a register above the map size acts as the map size
    logic [CNT_W-1:0] ncells;
    logic [CNT_W-1:0] ncalos;

    assign ncells = (CNT_W'(cells_cfg_reg) > MAX_CELLS_C) ? MAX_CELLS_C
                                                          : CNT_W'(cells_cfg_reg);
    assign ncalos = (CNT_W'(calos_cfg_reg) > MAX_CALOS_C) ? MAX_CALOS_C
                                                          : CNT_W'(calos_cfg_reg);

    // ------------------------------------------------------------------
    // Stage 0: accept, range check, issue map read
    // ------------------------------------------------------------------
    logic      in_accept;
    logic      id_in_range;
    req_type_t s0_op;

    logic             sweep_active_reg;
    logic [SW_AW-1:0] sweep_cnt_reg;

    req_type_t        s1_op_reg;
    logic [ID_W-1:0]  s1_id_reg;
    logic             s1_fwd_reg;

    // an end request in stage 1 also blocks, so nothing slips into the sweep
    assign busy      = sweep_active_reg || (s1_op_reg == REQ_END);
    assign in_accept = start && !busy;

    always_comb
    begin
        id_in_range = 1'b0;
        s0_op       = REQ_NONE;
        case (req_type_t'(req_type))
            REQ_CELL:
            begin
                id_in_range = CNT_W'(hit_id) < ncells;
                s0_op       = id_in_range ? REQ_CELL : REQ_NONE;
            end
            REQ_CALO:
            begin
                id_in_range = CNT_W'(hit_id) < ncalos;
                s0_op       = id_in_range ? REQ_CALO : REQ_NONE;
            end
            REQ_END:  s0_op = REQ_END;
            default:  s0_op = REQ_NONE;
        endcase
    end

    // a hit on the id that stage 1 is writing sees it as marked
    logic s0_fwd;
    assign s0_fwd = (s0_op == s1_op_reg) && (hit_id == s1_id_reg)
                 && ((s0_op == REQ_CELL) || (s0_op == REQ_CALO));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg <= REQ_NONE;
        end
        else
        begin
            s1_op_reg <= in_accept ? s0_op : REQ_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_id_reg  <= hit_id;
            s1_fwd_reg <= s0_fwd;
        end
    end

    // ------------------------------------------------------------------
    // Seen maps
    // ------------------------------------------------------------------
    logic               cell_rd_en, calo_rd_en;
    logic               cell_rd_data, calo_rd_data;
    logic               cell_wr_en, calo_wr_en;
    logic [CELL_AW-1:0] cell_wr_addr;
    logic [CALO_AW-1:0] calo_wr_addr;
    logic               map_wr_data;
    logic               s1_seen;

    assign cell_rd_en = in_accept && (s0_op == REQ_CELL);
    assign calo_rd_en = in_accept && (s0_op == REQ_CALO);

    always_comb
    begin
        s1_seen = 1'b0;
        case (s1_op_reg)
            REQ_CELL: s1_seen = cell_rd_data || s1_fwd_reg;
            REQ_CALO: s1_seen = calo_rd_data || s1_fwd_reg;
            default:  s1_seen = 1'b0;
        endcase
    end

    // write port: clearing sweep or first-hit mark, never both
    always_comb
    begin
        if (sweep_active_reg)
        begin
            cell_wr_en   = CNT_W'(sweep_cnt_reg) < MAX_CELLS_C;
            calo_wr_en   = CNT_W'(sweep_cnt_reg) < MAX_CALOS_C;
            cell_wr_addr = sweep_cnt_reg[CELL_AW-1:0];
            calo_wr_addr = sweep_cnt_reg[CALO_AW-1:0];
            map_wr_data  = 1'b0;
        end
        else
        begin
            cell_wr_en   = (s1_op_reg == REQ_CELL) && !s1_seen;
            calo_wr_en   = (s1_op_reg == REQ_CALO) && !s1_seen;
            cell_wr_addr = s1_id_reg[CELL_AW-1:0];
            calo_wr_addr = s1_id_reg[CALO_AW-1:0];
            map_wr_data  = 1'b1;
        end
    end

    hofc_seen_map #(
        .DEPTH (MAX_CELLS)
    ) u_cell_map (
        .clk     (clk),
        .rd_en   (cell_rd_en),
        .rd_addr (hit_id[CELL_AW-1:0]),
        .rd_data (cell_rd_data),
        .wr_en   (cell_wr_en),
        .wr_addr (cell_wr_addr),
        .wr_data (map_wr_data)
    );

    hofc_seen_map #(
        .DEPTH (MAX_CALOS)
    ) u_calo_map (
        .clk     (clk),
        .rd_en   (calo_rd_en),
        .rd_addr (hit_id[CALO_AW-1:0]),
        .rd_data (calo_rd_data),
        .wr_en   (calo_wr_en),
        .wr_addr (calo_wr_addr),
        .wr_data (map_wr_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: counters, result, sweep control
    // ------------------------------------------------------------------
    logic [OVERLAP_W-1:0] repeat_reg, repeat_next;
    logic [FREE_W-1:0]    distinct_reg, distinct_next;
    logic                 s1_hit;
    logic                 s1_end;

    assign s1_hit = (s1_op_reg == REQ_CELL) || (s1_op_reg == REQ_CALO);
    assign s1_end = (s1_op_reg == REQ_END);

    always_comb
    begin
        repeat_next   = repeat_reg;
        distinct_next = distinct_reg;
        if (s1_end)
        begin
            repeat_next   = '0;
            distinct_next = '0;
        end
        else if (s1_hit)
        begin
            if (s1_seen)
            begin
                if (repeat_reg != REPEAT_MAX)
                begin
                    repeat_next = repeat_reg + 1'b1;
                end
            end
            else if (distinct_reg != COUNT_MAX)
            begin
                distinct_next = distinct_reg + 1'b1;
            end
        end
    end

    // free = cells + calos - marked, clamped to [0, COUNT_MAX]
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  free_diff;
    logic [FREE_W-1:0] free_next;

    always_comb
    begin
        total     = TOT_W'(ncells) + TOT_W'(ncalos);
        free_diff = '0;
        if (total > TOT_W'(distinct_reg))
        begin
            free_diff = total - TOT_W'(distinct_reg);
        end
        if (free_diff > TOT_W'(COUNT_MAX))
        begin
            free_next = COUNT_MAX;
        end
        else
        begin
            free_next = free_diff[FREE_W-1:0];
        end
    end

    logic                 done_reg;
    logic [OVERLAP_W-1:0] overlap_out_reg;
    logic [FREE_W-1:0]    free_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_reg       <= '0;
            distinct_reg     <= '0;
            done_reg         <= 1'b0;
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
        end
        else
        begin
            repeat_reg   <= repeat_next;
            distinct_reg <= distinct_next;
            done_reg     <= s1_end;
            if (s1_end)
            begin
                sweep_active_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
            end
            else if (sweep_active_reg)
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_active_reg <= 1'b0;
                end
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_end)
        begin
            overlap_out_reg <= repeat_reg;
            free_out_reg    <= free_next;
        end
    end

    assign done          = done_reg;
    assign overlap_count = overlap_out_reg;
    assign free_count    = free_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_accept && (req_type_t'(req_type) == REQ_END), 2))
        else $error("done without a matching end request");

    a_sweep_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> sweep_active_reg)
        else $error("no clearing sweep after a result");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_active_reg |-> (s1_op_reg == REQ_NONE))
        else $error("pending request during clearing sweep");

    a_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_active_reg |-> ((repeat_reg == '0) && (distinct_reg == '0)))
        else $error("counters not clear during sweep");

endmodule
